// File: hw/rtl/stpm_pkg.sv
`timescale 1ns / 1ps

package stpm_pkg;

	// Field widths of one queued frame and of one result beat.
	localparam int STAMP_W = 48;
	localparam int TAG_W   = 16;
	localparam int ENTRY_W = STAMP_W + TAG_W;
	localparam int TOL_W   = 32;
	localparam int EV_W    = 2;
	localparam int OUT_W   = 2 * TAG_W + STAMP_W;

	// Tolerance after reset: 0.05 s in nanoseconds.
	localparam logic [TOL_W-1:0] TOL_RESET = 32'd50000000;

	// Results one arrival may cause before the matching loop pauses.
	localparam int MAX_RESULTS = 17;
	localparam int N_W         = 5;

	// Event codes of a result beat.
	localparam logic [EV_W-1:0] EV_PAIR       = 2'd0;
	localparam logic [EV_W-1:0] EV_LEFT_DROP  = 2'd1;
	localparam logic [EV_W-1:0] EV_RIGHT_DROP = 2'd2;
	localparam logic [EV_W-1:0] EV_FULL       = 2'd3;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_CHECK,
		ST_READ,
		ST_SUB_FWD,
		ST_SUB_ABS,
		ST_SUB_TOL,
		ST_EMIT
	} state_t;

	// Control of one frame queue.
	typedef struct packed {
		logic push;
		logic pop;
		logic rd;
	} queue_ctrl_t;

endpackage

// File: hw/rtl/stpm_sub.sv
`timescale 1ns / 1ps

// Shared subtractor: a minus b with the borrow out, used for every compare.
module stpm_sub import stpm_pkg::*; (
	input  logic [STAMP_W-1:0] a,
	input  logic [STAMP_W-1:0] b,
	output logic [STAMP_W-1:0] diff,
	output logic               borrow
);

	logic [STAMP_W:0] full_diff;

	assign full_diff = {1'b0, a} - {1'b0, b};
	assign diff      = full_diff[STAMP_W-1:0];
	assign borrow    = full_diff[STAMP_W];

endmodule

// File: hw/rtl/stpm_queue.sv
`timescale 1ns / 1ps

// Circular frame queue with a registered read of the front entry.
module stpm_queue import stpm_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  queue_ctrl_t                  ctrl,
	input  logic [ENTRY_W-1:0]           wr_data,
	output logic [ENTRY_W-1:0]           rd_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      tail_q;
	logic [CW-1:0]      count_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// Storage: one write and one read port, read data registered.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= wr_data;
		end
		if (ctrl.rd) begin
			rd_data_q <= mem[head_q];
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= wrap_inc(tail_q);
			end
			if (ctrl.pop) begin
				head_q <= wrap_inc(head_q);
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rd_data = rd_data_q;
	assign count   = count_q;

endmodule

// File: hw/rtl/stereo_timestamp_pair_matcher.sv
`timescale 1ns / 1ps

// Pairs left and right camera frames by capture time. Each input beat is one
// frame arrival that goes into its side's queue of QUEUE_DEPTH entries; then,
// while both queues hold frames, the two fronts are compared: a difference
// strictly below tolerance_ns gives a pair stamped with the left time, and
// anything else drops the older front (the left one on equal stamps). A frame
// arriving at a full queue is dropped and reported first. The block takes one
// arrival at a time. After it is accepted, the arrival is pushed into its
// queue or, if that queue is full, turned into a drop report; then each
// compare result takes the check of both queue counts, the front read, three
// passes through the single 48-bit subtractor for the signed difference, its
// magnitude and the tolerance compare, then the load of the output register.
// A check that finds a queue empty ends the arrival without a compare. One
// arrival gives at most seventeen results, and a result can wait for the
// downstream side. Queue contents need no clearing after reset; the block is
// ready as soon as reset is released.
module stereo_timestamp_pair_matcher import stpm_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration: tolerance_ns.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TOL_W-1:0]     cfg_data,
	// Frame arrivals.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [ENTRY_W-1:0]   s_tdata,   // stamp[47:0], tag[63:48]
	input  logic                 s_tuser,   // kind[0]
	// Results.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // left_tag[15:0], right_tag[31:16], out_stamp[79:32]
	output logic [EV_W-1:0]      m_tuser,   // event_res[1:0]
	output logic                 m_tlast
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;

	logic [TOL_W-1:0]   tol_q;
	logic               in_kind_q;
	logic [STAMP_W-1:0] in_stamp_q;
	logic [TAG_W-1:0]   in_tag_q;
	logic [N_W-1:0]     n_q;
	logic               lt_q;
	logic               gt_q;
	logic [STAMP_W-1:0] diff_q;

	logic [EV_W-1:0]    res_ev_q;
	logic [TAG_W-1:0]   res_ltag_q;
	logic [TAG_W-1:0]   res_rtag_q;
	logic [STAMP_W-1:0] res_stamp_q;
	logic               res_last_q;
	logic               pop_l_q;
	logic               pop_r_q;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic [EV_W-1:0]    m_tuser_q;
	logic               m_tlast_q;

	queue_ctrl_t        lq_ctrl, rq_ctrl;
	logic [ENTRY_W-1:0] l_rd, r_rd;
	logic [CW-1:0]      l_count, r_count;
	logic               l_full, r_full;

	logic [STAMP_W-1:0] ls, rs;
	logic [TAG_W-1:0]   ltag, rtag;
	logic [STAMP_W-1:0] sub_a, sub_b, sub_diff;
	logic               sub_borrow;

	logic               s_accept;
	logic               out_free;
	logic               emit_go;
	logic               both_ready;
	logic               dec_pop_l, dec_pop_r;
	logic [CW-1:0]      next_l_count, next_r_count;
	logic               dec_last;

	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign emit_go  = (state_q == ST_EMIT) && out_free;

	assign l_full = (l_count == CW'(QUEUE_DEPTH));
	assign r_full = (r_count == CW'(QUEUE_DEPTH));

	assign ls   = l_rd[ENTRY_W-1:TAG_W];
	assign ltag = l_rd[TAG_W-1:0];
	assign rs   = r_rd[ENTRY_W-1:TAG_W];
	assign rtag = r_rd[TAG_W-1:0];

	// Frame queues, one per camera.
	stpm_queue #(.DEPTH(QUEUE_DEPTH)) u_left_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (lq_ctrl),
		.wr_data ({in_stamp_q, in_tag_q}),
		.rd_data (l_rd),
		.count   (l_count)
	);

	stpm_queue #(.DEPTH(QUEUE_DEPTH)) u_right_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (rq_ctrl),
		.wr_data ({in_stamp_q, in_tag_q}),
		.rd_data (r_rd),
		.count   (r_count)
	);

	// The one subtractor shared by all compare steps.
	stpm_sub u_sub (
		.a      (sub_a),
		.b      (sub_b),
		.diff   (sub_diff),
		.borrow (sub_borrow)
	);

	// Outcome of the tolerance compare and whether it ends this arrival.
	always_comb begin
		dec_pop_l    = sub_borrow || !gt_q;
		dec_pop_r    = sub_borrow || gt_q;
		next_l_count = l_count - CW'(dec_pop_l);
		next_r_count = r_count - CW'(dec_pop_r);
		dec_last     = (next_l_count == '0) || (next_r_count == '0) ||
		               (n_q == N_W'(MAX_RESULTS - 1));
	end

	assign both_ready = (l_count != '0) && (r_count != '0) && (n_q < N_W'(MAX_RESULTS));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if ((in_kind_q && r_full) || (!in_kind_q && l_full)) state_d = ST_EMIT;
				else state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (both_ready) state_d = ST_READ;
				else state_d = ST_IDLE;
			end
			ST_READ:    state_d = ST_SUB_FWD;
			ST_SUB_FWD: state_d = ST_SUB_ABS;
			ST_SUB_ABS: state_d = ST_SUB_TOL;
			ST_SUB_TOL: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = res_last_q ? ST_IDLE : ST_CHECK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, queue control and subtractor operands.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		lq_ctrl.push = (state_q == ST_PUSH) && !in_kind_q && !l_full;
		rq_ctrl.push = (state_q == ST_PUSH) && in_kind_q && !r_full;
		lq_ctrl.pop  = emit_go && pop_l_q;
		rq_ctrl.pop  = emit_go && pop_r_q;
		lq_ctrl.rd   = (state_q == ST_READ);
		rq_ctrl.rd   = (state_q == ST_READ);
		sub_a = '0;
		sub_b = '0;
		case (state_q)
			ST_SUB_FWD: begin
				sub_a = ls;
				sub_b = rs;
			end
			ST_SUB_ABS: begin
				sub_a = lt_q ? rs : ls;
				sub_b = lt_q ? ls : rs;
			end
			ST_SUB_TOL: begin
				sub_a = diff_q;
				sub_b = {{(STAMP_W-TOL_W){1'b0}}, tol_q};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tol_q      <= TOL_RESET;
			n_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			if (state_q == ST_PUSH) begin
				n_q <= ((in_kind_q && r_full) || (!in_kind_q && l_full)) ? N_W'(1) : '0;
			end else if (emit_go && (res_ev_q != EV_FULL)) begin
				n_q <= n_q + N_W'(1);
			end
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the current arrival and its pending result.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			in_kind_q  <= s_tuser;
			in_stamp_q <= s_tdata[STAMP_W-1:0];
			in_tag_q   <= s_tdata[ENTRY_W-1:STAMP_W];
		end
		case (state_q)
			ST_PUSH: begin
				// A full queue turns the arrival into a drop report.
				res_ev_q    <= EV_FULL;
				res_ltag_q  <= in_kind_q ? '0 : in_tag_q;
				res_rtag_q  <= in_kind_q ? in_tag_q : '0;
				res_stamp_q <= in_stamp_q;
				res_last_q  <= in_kind_q ? (l_count == '0) : (r_count == '0);
				pop_l_q     <= 1'b0;
				pop_r_q     <= 1'b0;
			end
			ST_SUB_FWD: begin
				diff_q <= sub_diff;
				lt_q   <= sub_borrow;
				gt_q   <= !sub_borrow && (sub_diff != '0);
			end
			ST_SUB_ABS: begin
				diff_q <= sub_diff;
			end
			ST_SUB_TOL: begin
				if (sub_borrow) begin
					res_ev_q    <= EV_PAIR;
					res_ltag_q  <= ltag;
					res_rtag_q  <= rtag;
					res_stamp_q <= ls;
				end else if (gt_q) begin
					res_ev_q    <= EV_RIGHT_DROP;
					res_ltag_q  <= '0;
					res_rtag_q  <= rtag;
					res_stamp_q <= rs;
				end else begin
					res_ev_q    <= EV_LEFT_DROP;
					res_ltag_q  <= ltag;
					res_rtag_q  <= '0;
					res_stamp_q <= ls;
				end
				res_last_q <= dec_last;
				pop_l_q    <= dec_pop_l;
				pop_r_q    <= dec_pop_r;
			end
			default: begin
			end
		endcase
		if (emit_go) begin
			m_tdata_q <= {res_stamp_q, res_rtag_q, res_ltag_q};
			m_tuser_q <= res_ev_q;
			m_tlast_q <= res_last_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign m_tlast   = m_tlast_q;

	// A queue is never written while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(lq_ctrl.push |-> !l_full) and (rq_ctrl.push |-> !r_full))
		else $error("push to a full frame queue");

	// A queue is never popped while empty.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(lq_ctrl.pop |-> (l_count != '0)) and (rq_ctrl.pop |-> (r_count != '0)))
		else $error("pop from an empty frame queue");

	// Every compare result removes at least one front frame.
	a_compare_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && (res_ev_q != EV_FULL)) |-> (pop_l_q || pop_r_q))
		else $error("compare result without a pop");

	// A pair always pops both fronts.
	a_pair_pops_both: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && (res_ev_q == EV_PAIR)) |-> (pop_l_q && pop_r_q))
		else $error("pair result without popping both queues");

	// No new arrival is taken in the cycle after one was accepted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready)
		else $error("arrival accepted while the previous one is in work");

endmodule
